// ----- sv/drive_command_slew_limiter_assert.svh -----
`ifndef DRIVE_COMMAND_SLEW_LIMITER_ASSERT_SVH
`define DRIVE_COMMAND_SLEW_LIMITER_ASSERT_SVH

// Both macros expect signals named clk and rst in the scope where they are used.
`define DCSL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define DCSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dcsl_pkg.sv -----
package dcsl_pkg;

  localparam logic signed [15:0] CONTROL_LIMIT = 16'sd1000;
  localparam logic signed [15:0] BRAKE_LIMIT   = 16'sd1000;
  localparam logic signed [15:0] CONTROL_MIN   = -CONTROL_LIMIT;
  localparam logic signed [15:0] BRAKE_MIN     = 16'sd0;

  localparam logic [1:0] OP_EVAL    = 2'd0;
  localparam logic [1:0] OP_NOTE    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] DEC_ACCEPT  = 2'd0;
  localparam logic [1:0] DEC_NOT_CFG = 2'd1;
  localparam logic [1:0] DEC_LIMITER = 2'd2;

  localparam logic [1:0] DET_NONE     = 2'd0;
  localparam logic [1:0] DET_NOT_CFG  = 2'd1;
  localparam logic [1:0] DET_RANGE    = 2'd2;
  localparam logic [1:0] DET_TOO_SOON = 2'd3;

  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_THR_LIMITS   = 3'd1;
  localparam logic [2:0] REG_STEER_LIMITS = 3'd2;
  localparam logic [2:0] REG_BRAKE_LIMITS = 3'd3;
  localparam logic [2:0] REG_THR_STEPS    = 3'd4;
  localparam logic [2:0] REG_STEER_STEPS  = 3'd5;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd6;

  typedef struct packed {
    logic        enable;
    logic [31:0] thr_lim;
    logic [31:0] str_lim;
    logic [31:0] brk_lim;
    logic [31:0] thr_steps;
    logic [31:0] str_steps;
    logic [15:0] min_interval;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        last_time;
    logic               has_history;
    logic signed [15:0] last_throttle;
    logic signed [15:0] last_steer;
  } hist_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         decision;
    logic [1:0]         detail;
    logic signed [15:0] throttle;
    logic signed [15:0] steer;
  } verdict_t;

  function automatic logic pair_ok(input logic [31:0] r, input logic signed [15:0] lo,
                                   input logic signed [15:0] hi);
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    mn = signed'(r[15:0]);
    mx = signed'(r[31:16]);
    return (mn >= lo) && (mx <= hi) && (mn <= mx);
  endfunction

  function automatic logic in_pair(input logic signed [15:0] v, input logic [31:0] r);
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    mn = signed'(r[15:0]);
    mx = signed'(r[31:16]);
    return (v >= mn) && (v <= mx);
  endfunction

endpackage

// ----- sv/dcsl_cfg_regs.sv -----
module dcsl_cfg_regs
  import dcsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_THR_LIMITS:   cfg.thr_lim      <= cfg_data;
        REG_STEER_LIMITS: cfg.str_lim      <= cfg_data;
        REG_BRAKE_LIMITS: cfg.brk_lim      <= cfg_data;
        REG_THR_STEPS:    cfg.thr_steps    <= cfg_data;
        REG_STEER_STEPS:  cfg.str_steps    <= cfg_data;
        REG_MIN_INTERVAL: cfg.min_interval <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/dcsl_step.sv -----
module dcsl_step
  import dcsl_pkg::*;
(
  input  logic signed [15:0] cur,
  input  logic signed [15:0] tgt,
  input  logic [15:0]        rise,
  input  logic [15:0]        fall,
  output logic signed [15:0] nxt
);

  logic               returning;
  logic [15:0]        step;
  logic signed [17:0] cur_x;
  logic signed [17:0] tgt_x;
  logic signed [17:0] step_x;
  logic signed [17:0] up;
  logic signed [17:0] dn;

  // A move is returning when it heads to zero, crosses zero, or shrinks toward zero.
  assign returning = (tgt == 16'sd0) ||
                     ((cur != 16'sd0) && (cur[15] != tgt[15])) ||
                     (!tgt[15] ? (tgt < cur) : (tgt > cur));
  assign step   = returning ? fall : rise;
  assign cur_x  = signed'({{2{cur[15]}}, cur});
  assign tgt_x  = signed'({{2{tgt[15]}}, tgt});
  assign step_x = signed'({2'b00, step});
  assign up     = cur_x + step_x;
  assign dn     = cur_x - step_x;

  always_comb begin
    if ((step == 16'd0) || (cur == tgt)) begin
      nxt = tgt;
    end else if (cur < tgt) begin
      nxt = (up > tgt_x) ? tgt : up[15:0];
    end else begin
      nxt = (dn < tgt_x) ? tgt : dn[15:0];
    end
  end

endmodule

// ----- sv/dcsl_eval.sv -----
module dcsl_eval
  import dcsl_pkg::*;
(
  input  cfg_t               cfg,
  input  hist_t              hist,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] thr,
  input  logic signed [15:0] str,
  input  logic signed [15:0] brk,
  output verdict_t           verdict
);

  logic               configured;
  logic               in_range;
  logic               too_soon;
  logic               reversal;
  logic signed [15:0] thr_tgt;
  logic signed [15:0] thr_next;
  logic signed [15:0] str_next;
  logic [31:0]        elapsed;

  assign configured = cfg.enable &&
                      pair_ok(cfg.thr_lim, CONTROL_MIN, CONTROL_LIMIT) &&
                      pair_ok(cfg.str_lim, CONTROL_MIN, CONTROL_LIMIT) &&
                      pair_ok(cfg.brk_lim, BRAKE_MIN, BRAKE_LIMIT);

  assign in_range = (thr >= CONTROL_MIN) && (thr <= CONTROL_LIMIT) &&
                    (str >= CONTROL_MIN) && (str <= CONTROL_LIMIT) &&
                    (brk >= BRAKE_MIN) && (brk <= BRAKE_LIMIT) &&
                    in_pair(thr, cfg.thr_lim) && in_pair(str, cfg.str_lim) &&
                    in_pair(brk, cfg.brk_lim);

  assign elapsed  = now_ms - hist.last_time;
  assign too_soon = hist.has_history && (cfg.min_interval != 16'd0) &&
                    (elapsed < {16'd0, cfg.min_interval});

  // A throttle sign reversal parks the throttle at zero first.
  assign reversal = (hist.last_throttle != 16'sd0) && (thr != 16'sd0) &&
                    (hist.last_throttle[15] != thr[15]);
  assign thr_tgt  = reversal ? 16'sd0 : thr;

  dcsl_step u_thr_step (
    .cur  (hist.last_throttle),
    .tgt  (thr_tgt),
    .rise (cfg.thr_steps[15:0]),
    .fall (cfg.thr_steps[31:16]),
    .nxt  (thr_next)
  );

  dcsl_step u_str_step (
    .cur  (hist.last_steer),
    .tgt  (str),
    .rise (cfg.str_steps[15:0]),
    .fall (cfg.str_steps[31:16]),
    .nxt  (str_next)
  );

  always_comb begin
    verdict.accepted = 1'b0;
    verdict.decision = DEC_ACCEPT;
    verdict.detail   = DET_NONE;
    verdict.throttle = thr;
    verdict.steer    = str;
    if (!configured) begin
      verdict.decision = DEC_NOT_CFG;
      verdict.detail   = DET_NOT_CFG;
    end else if (!in_range) begin
      verdict.decision = DEC_LIMITER;
      verdict.detail   = DET_RANGE;
    end else if (too_soon) begin
      verdict.decision = DEC_LIMITER;
      verdict.detail   = DET_TOO_SOON;
    end else begin
      verdict.accepted = 1'b1;
      if (hist.has_history) begin
        verdict.throttle = thr_next;
        verdict.steer    = str_next;
      end
    end
  end

endmodule

// ----- sv/drive_command_slew_limiter.sv -----
// A request is held in the request register and its result in the result register;
// one request per cycle unless a stalled result holds the flow; those two registers
// are the two stages, with the whole evaluation in the logic between them.
// Note and restart requests update the history and produce no result.
// Reset (synchronous, active high) clears the configuration, history and valid flags.
module drive_command_slew_limiter
  import dcsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         op,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] throttle_cmd,
  input  logic signed [15:0] steer_cmd,
  input  logic signed [15:0] brake_cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               accepted,
  output logic [1:0]         decision,
  output logic [1:0]         detail,
  output logic signed [15:0] throttle_out,
  output logic signed [15:0] steer_out,
  output logic signed [15:0] brake_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t               cfg;
  hist_t              hist;
  verdict_t           verdict;
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic [31:0]        s1_now;
  logic signed [15:0] s1_thr;
  logic signed [15:0] s1_str;
  logic signed [15:0] s1_brk;
  logic               s1_adv;
  logic               s1_eval;

  assign cfg_ready = 1'b1;

  dcsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcsl_eval u_eval (
    .cfg     (cfg),
    .hist    (hist),
    .now_ms  (s1_now),
    .thr     (s1_thr),
    .str     (s1_str),
    .brk     (s1_brk),
    .verdict (verdict)
  );

  assign s1_eval   = s1_valid && (s1_op == OP_EVAL);
  assign s1_adv    = s1_valid && (!s1_eval || !res_valid || !res_stall);
  assign cmd_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_op  <= op;
      s1_now <= now_ms;
      s1_thr <= throttle_cmd;
      s1_str <= steer_cmd;
      s1_brk <= brake_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (s1_adv) begin
      case (s1_op)
        OP_NOTE: begin
          hist.last_time     <= s1_now;
          hist.last_throttle <= s1_thr;
          hist.last_steer    <= s1_str;
          hist.has_history   <= 1'b1;
        end
        OP_RESTART: begin
          hist.last_time     <= s1_now;
          hist.last_throttle <= 16'sd0;
          hist.last_steer    <= 16'sd0;
          hist.has_history   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_eval) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_eval) begin
      accepted     <= verdict.accepted;
      decision     <= verdict.decision;
      detail       <= verdict.detail;
      throttle_out <= verdict.throttle;
      steer_out    <= verdict.steer;
      brake_out    <= s1_brk;
    end
  end

endmodule

// ----- sv/dcsl_checker.sv -----
`include "drive_command_slew_limiter_assert.svh"

module dcsl_checker
  import dcsl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input logic               accepted,
  input logic [1:0]         decision,
  input logic [1:0]         detail,
  input logic signed [15:0] brake_out
);

  `DCSL_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid, "stalled result dropped")
  `DCSL_ASSERT_IMPLY(a_acc_codes, res_valid && accepted,
    (decision == DEC_ACCEPT) && (detail == DET_NONE), "accepted result carries a reject code")
  `DCSL_ASSERT_IMPLY(a_rej_codes, res_valid && !accepted,
    (decision != DEC_ACCEPT) && (detail != DET_NONE), "rejected result carries accept codes")
  `DCSL_ASSERT_IMPLY(a_not_cfg, res_valid && (detail == DET_NOT_CFG),
    decision == DEC_NOT_CFG, "not configured detail with wrong decision")
  `DCSL_ASSERT_IMPLY(a_brake_range, res_valid && accepted,
    (brake_out >= BRAKE_MIN) && (brake_out <= BRAKE_LIMIT), "accepted brake out of range")

endmodule

bind drive_command_slew_limiter dcsl_checker u_dcsl_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dcsl_pkg::*;

  localparam int CTRL_MAX = int'(CONTROL_LIMIT);
  localparam int BRAKE_MAX = int'(BRAKE_LIMIT);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    logic               accepted;
    logic [1:0]         decision;
    logic [1:0]         detail;
    logic signed [15:0] throttle;
    logic signed [15:0] steer;
    logic signed [15:0] brake;
  } drive_verdict_t;

  class drive_cmd_scoreboard;
    cfg_t regs;
    hist_t hist;
    drive_verdict_t pending_verdicts[$];
    drive_verdict_t last_verdict;
    int errors;

    function new();
      regs = '0;
      hist = '0;
      errors = 0;
      last_verdict = '{1'b0, DEC_ACCEPT, DET_NONE, 16'sd0, 16'sd0, 16'sd0};
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_ENABLE:       regs.enable = data[0];
        REG_THR_LIMITS:   regs.thr_lim = data;
        REG_STEER_LIMITS: regs.str_lim = data;
        REG_BRAKE_LIMITS: regs.brk_lim = data;
        REG_THR_STEPS:    regs.thr_steps = data;
        REG_STEER_STEPS:  regs.str_steps = data;
        REG_MIN_INTERVAL: regs.min_interval = data[15:0];
        default: ;
      endcase
    endfunction

    function bit bounds_valid(logic [31:0] r, int lo, int hi);
      int mn;
      int mx;
      mn = $signed(r[15:0]);
      mx = $signed(r[31:16]);
      return mn >= lo && mx <= hi && mn <= mx;
    endfunction

    function bit in_bounds(int v, logic [31:0] r);
      int mn;
      int mx;
      mn = $signed(r[15:0]);
      mx = $signed(r[31:16]);
      return v >= mn && v <= mx;
    endfunction

    function int approach(int cur, int tgt, int step);
      if (step == 0 || cur == tgt) return tgt;
      if (cur < tgt) return (cur + step > tgt) ? tgt : cur + step;
      return (cur - step < tgt) ? tgt : cur - step;
    endfunction

    // A move counts as easing off when it heads to zero, crosses it, or shrinks toward it.
    function bit easing_off(int cur, int tgt);
      if (tgt == 0) return 1'b1;
      if (cur != 0 && ((cur < 0) != (tgt < 0))) return 1'b1;
      return (tgt >= 0) ? (tgt < cur) : (tgt > cur);
    endfunction

    function drive_verdict_t predict_verdict(logic [31:0] now, logic signed [15:0] thr_in,
                                             logic signed [15:0] str_in,
                                             logic signed [15:0] brk_in);
      drive_verdict_t v;
      int thr;
      int str;
      int brk;
      int cur_t;
      int cur_s;
      int target_t;
      int step_t;
      int step_s;
      logic [31:0] elapsed;
      bit configured;
      bit in_range;
      bit flip;
      thr = thr_in;
      str = str_in;
      brk = brk_in;
      cur_t = hist.last_throttle;
      cur_s = hist.last_steer;
      elapsed = now - hist.last_time;
      configured = regs.enable && bounds_valid(regs.thr_lim, -CTRL_MAX, CTRL_MAX) &&
                   bounds_valid(regs.str_lim, -CTRL_MAX, CTRL_MAX) &&
                   bounds_valid(regs.brk_lim, 0, BRAKE_MAX);
      in_range = thr >= -CTRL_MAX && thr <= CTRL_MAX && str >= -CTRL_MAX && str <= CTRL_MAX &&
                 brk >= 0 && brk <= BRAKE_MAX && in_bounds(thr, regs.thr_lim) &&
                 in_bounds(str, regs.str_lim) && in_bounds(brk, regs.brk_lim);
      v = '{1'b0, DEC_ACCEPT, DET_NONE, thr_in, str_in, brk_in};
      if (!configured) begin
        v.decision = DEC_NOT_CFG;
        v.detail = DET_NOT_CFG;
      end else if (!in_range) begin
        v.decision = DEC_LIMITER;
        v.detail = DET_RANGE;
      end else if (hist.has_history && regs.min_interval != 16'd0 &&
                   elapsed < {16'd0, regs.min_interval}) begin
        v.decision = DEC_LIMITER;
        v.detail = DET_TOO_SOON;
      end else begin
        v.accepted = 1'b1;
        if (hist.has_history) begin
          flip = cur_t != 0 && thr != 0 && ((cur_t < 0) != (thr < 0));
          target_t = flip ? 0 : thr;
          step_t = easing_off(cur_t, target_t) ? regs.thr_steps[31:16] : regs.thr_steps[15:0];
          step_s = easing_off(cur_s, str) ? regs.str_steps[31:16] : regs.str_steps[15:0];
          v.throttle = 16'(approach(cur_t, target_t, step_t));
          v.steer = 16'(approach(cur_s, str, step_s));
        end
      end
      return v;
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] now, logic signed [15:0] thr,
                               logic signed [15:0] str, logic signed [15:0] brk);
      case (kind)
        OP_EVAL: begin
          last_verdict = predict_verdict(now, thr, str, brk);
          pending_verdicts.push_back(last_verdict);
        end
        OP_NOTE: begin
          hist.last_time = now;
          hist.last_throttle = thr;
          hist.last_steer = str;
          hist.has_history = 1'b1;
        end
        OP_RESTART: begin
          hist.last_time = now;
          hist.last_throttle = 16'sd0;
          hist.last_steer = 16'sd0;
          hist.has_history = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      end
    endfunction

    function void check_result(drive_verdict_t got);
      drive_verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: expected none got decision %0d",
                 $time, got.decision);
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
      compare_field("decision", 16'(want.decision), 16'(got.decision));
      compare_field("detail", 16'(want.detail), 16'(got.detail));
      compare_field("throttle_out", want.throttle, got.throttle);
      compare_field("steer_out", want.steer, got.steer);
      compare_field("brake_out", want.brake, got.brake);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [1:0]         op;
  logic [31:0]        now_ms;
  logic signed [15:0] throttle_cmd;
  logic signed [15:0] steer_cmd;
  logic signed [15:0] brake_cmd;
  logic               res_valid;
  logic               res_stall;
  logic               accepted;
  logic [1:0]         decision;
  logic [1:0]         detail;
  logic signed [15:0] throttle_out;
  logic signed [15:0] steer_out;
  logic signed [15:0] brake_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  drive_cmd_scoreboard sb;
  cfg_t live_cfg;
  logic [31:0] sim_ms = 32'd0;
  bit back_to_back = 1'b0;
  bit hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  drive_command_slew_limiter i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    drive_verdict_t seen;
    if (!rst && res_valid && !res_stall) begin
      seen = '{accepted, decision, detail, throttle_out, steer_out, brake_out};
      sb.check_result(seen);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : result_sink
    int stall_len;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          res_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        res_stall <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end
    end
  end

  function automatic cfg_t mk_cfg(bit en, logic [31:0] tl, logic [31:0] sl, logic [31:0] bl,
                                  logic [31:0] ts, logic [31:0] ss, logic [15:0] mi);
    cfg_t c;
    c.enable = en;
    c.thr_lim = tl;
    c.str_lim = sl;
    c.brk_lim = bl;
    c.thr_steps = ts;
    c.str_steps = ss;
    c.min_interval = mi;
    return c;
  endfunction

  function automatic logic [31:0] span(int lo, int hi);
    return {16'(hi), 16'(lo)};
  endfunction

  function automatic logic [31:0] rand_pair(int abs_lo, int abs_hi);
    int lo;
    int hi;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom();
    if (r < 20) return span(abs_lo, abs_hi);
    lo = abs_lo + int'($urandom_range(0, abs_hi - abs_lo));
    hi = lo + int'($urandom_range(0, abs_hi - lo));
    return span(lo, hi);
  endfunction

  function automatic logic [15:0] rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 22) return 16'hFFFF;
    if (r < 30) return 16'($urandom());
    return 16'($urandom_range(1, 300));
  endfunction

  function automatic cfg_t rand_cfg();
    int r;
    logic [15:0] mi;
    r = $urandom_range(0, 99);
    if (r < 35) mi = 16'd0;
    else if (r < 40) mi = 16'hFFFF;
    else if (r < 50) mi = 16'($urandom());
    else mi = 16'($urandom_range(1, 40));
    return mk_cfg($urandom_range(0, 9) != 0, rand_pair(-CTRL_MAX, CTRL_MAX),
                  rand_pair(-CTRL_MAX, CTRL_MAX), rand_pair(0, BRAKE_MAX),
                  {rand_step(), rand_step()}, {rand_step(), rand_step()}, mi);
  endfunction

  function automatic int pick_value(logic [31:0] lim, int abs_lo, int abs_hi);
    int lo;
    int hi;
    int r;
    lo = $signed(lim[15:0]);
    hi = $signed(lim[31:16]);
    if (lo < abs_lo) lo = abs_lo;
    if (hi > abs_hi) hi = abs_hi;
    if (lo > hi) begin
      lo = abs_lo;
      hi = abs_hi;
    end
    r = $urandom_range(0, 99);
    if (r < 8) return lo;
    if (r < 16) return hi;
    if (r < 20) return lo - 1;
    if (r < 24) return hi + 1;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [31:0] advance_ms(logic [31:0] base, logic [15:0] spacing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom();
    if (r < 8) return 32'hFFFF_FFFF - $urandom_range(0, 20);
    return base + $urandom_range(0, 2 * spacing + 3);
  endfunction

  task automatic send_cmd(input logic [1:0] kind, input logic [31:0] stamp, input int thr,
                          input int str, input int brk);
    int gap;
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    op <= kind;
    now_ms <= stamp;
    throttle_cmd <= 16'(thr);
    steer_cmd <= 16'(str);
    brake_cmd <= 16'(brk);
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_request(kind, stamp, 16'(thr), 16'(str), 16'(brk));
  endtask

  task automatic program_config(input cfg_t c);
    logic [2:0] idx[8];
    logic [31:0] val[8];
    int writes;
    idx = '{REG_ENABLE, REG_THR_LIMITS, REG_STEER_LIMITS, REG_BRAKE_LIMITS, REG_THR_STEPS,
            REG_STEER_STEPS, REG_MIN_INTERVAL, REG_UNUSED};
    val = '{{31'($urandom()), c.enable}, c.thr_lim, c.str_lim, c.brk_lim, c.thr_steps,
            c.str_steps, {16'($urandom()), c.min_interval}, $urandom()};
    writes = ($urandom_range(0, 3) == 0) ? 8 : 7;
    for (int k = 0; k < writes; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    live_cfg = c;
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_eval_in_range();
    send_cmd(OP_EVAL, sim_ms, pick_value(live_cfg.thr_lim, -CTRL_MAX, CTRL_MAX),
             pick_value(live_cfg.str_lim, -CTRL_MAX, CTRL_MAX),
             pick_value(live_cfg.brk_lim, 0, BRAKE_MAX));
  endtask

  // Mostly evaluate requests, each accepted one usually noted next with its limited values.
  task automatic run_random(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      sim_ms = advance_ms(sim_ms, live_cfg.min_interval);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_cmd(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (r < 9) begin
        send_cmd(OP_RESTART, sim_ms, $urandom(), $urandom(), $urandom());
      end else if (r < 14) begin
        send_cmd(OP_NOTE, sim_ms, pick_value(live_cfg.thr_lim, -CTRL_MAX, CTRL_MAX),
                 pick_value(live_cfg.str_lim, -CTRL_MAX, CTRL_MAX), $urandom());
      end else begin
        send_eval_in_range();
        if (sb.last_verdict.accepted && $urandom_range(0, 9) < 8) begin
          send_cmd(OP_NOTE, sim_ms, sb.last_verdict.throttle, sb.last_verdict.steer,
                   sb.last_verdict.brake);
        end
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    live_cfg = '0;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    op <= OP_EVAL;
    now_ms <= 32'd0;
    throttle_cmd <= 16'sd0;
    steer_cmd <= 16'sd0;
    brake_cmd <= 16'sd0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data <= 32'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_EVAL, 32'd0, 0, 0, 0);
    send_cmd(OP_EVAL, 32'hFFFF_FFFF, -32768, 32767, 32767);
    settle();

    program_config(mk_cfg(1'b1, span(-CTRL_MAX, CTRL_MAX), span(-CTRL_MAX, CTRL_MAX),
                          span(0, BRAKE_MAX), {16'd250, 16'd100}, {16'd80, 16'd40}, 16'd0));
    send_cmd(OP_EVAL, 32'd10, 500, -300, 200);
    send_cmd(OP_EVAL, 32'd11, 1001, 0, 0);
    send_cmd(OP_EVAL, 32'd12, 0, -1001, 0);
    send_cmd(OP_EVAL, 32'd13, 0, 0, -1);
    send_cmd(OP_EVAL, 32'd14, 0, 0, 1001);
    send_cmd(OP_NOTE, 32'd100, 600, -200, 0);
    send_cmd(OP_EVAL, 32'd101, -400, 300, 500);
    send_cmd(OP_EVAL, 32'd102, 0, 0, 0);
    send_cmd(OP_EVAL, 32'd103, 900, -900, 1000);
    send_cmd(OP_EVAL, 32'd104, 300, -200, 0);
    send_cmd(OP_UNUSED, 32'd105, 1, 1, 1);
    send_cmd(OP_RESTART, 32'd1000, 0, 0, 0);
    send_cmd(OP_EVAL, 32'd1001, -1000, 1000, 0);
    settle();

    program_config(mk_cfg(1'b1, span(-200, 800), span(-500, 500), span(100, 900), 32'd0,
                          32'd0, 16'hFFFF));
    send_cmd(OP_NOTE, 32'hFFFF_FFF0, 10, 10, 0);
    send_cmd(OP_EVAL, 32'd5, 700, -500, 900);
    send_cmd(OP_EVAL, 32'd6, 900, 0, 500);
    send_cmd(OP_EVAL, 32'h0000_FFEF, 800, -400, 100);
    send_cmd(OP_EVAL, 32'h0001_0000, -201, 0, 500);
    send_cmd(OP_EVAL, 32'h0001_0000, 0, 0, 99);
    settle();

    program_config(mk_cfg(1'b1, span(5, -5), span(-CTRL_MAX, CTRL_MAX), span(0, BRAKE_MAX),
                          32'd0, 32'd0, 16'd0));
    send_cmd(OP_EVAL, 32'd0, 0, 0, 0);
    settle();
    program_config(mk_cfg(1'b1, span(-CTRL_MAX, CTRL_MAX), span(-CTRL_MAX, CTRL_MAX + 1),
                          span(-1, BRAKE_MAX), 32'd0, 32'd0, 16'd0));
    send_cmd(OP_EVAL, 32'd0, 0, 0, 0);
    settle();

    program_config(mk_cfg(1'b1, span(-CTRL_MAX, CTRL_MAX), span(-CTRL_MAX, CTRL_MAX),
                          span(0, BRAKE_MAX), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1));
    send_cmd(OP_NOTE, 32'd0, -1000, 1000, 0);
    send_cmd(OP_EVAL, 32'd1, 1000, -1000, 0);
    send_cmd(OP_EVAL, 32'd0, 0, 0, 0);
    settle();

    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        program_config(mk_cfg(1'b1, span(-CTRL_MAX, CTRL_MAX), span(-CTRL_MAX, CTRL_MAX),
                              span(0, BRAKE_MAX), {16'd60, 16'd30}, {16'd50, 16'd20}, 16'd0));
        // The sink holds off while requests keep coming, so the pipeline backs up.
        hold_pending = 1'b1;
        back_to_back = 1'b1;
        for (int k = 0; k < 24; k++) begin
          sim_ms = sim_ms + 32'd1;
          send_eval_in_range();
        end
        back_to_back = 1'b0;
      end else begin
        program_config(rand_cfg());
      end
      run_random(45);
      settle();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- drive_command_slew_limiter.f -----
+incdir+sv
sv/dcsl_pkg.sv
sv/dcsl_cfg_regs.sv
sv/dcsl_step.sv
sv/dcsl_eval.sv
sv/drive_command_slew_limiter.sv
sv/dcsl_checker.sv
tb/tb.sv
